>>> design/pcsc_pkg.sv
// Shared constants, codes and types for the pump command step controller.
package pcsc_pkg;

  localparam int COUNT_BITS = 14;
  localparam int TICK_BITS  = 8;
  localparam int CFG_BITS   = 14;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_POSITION = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_TICKS  = 2'd1;

  localparam logic [COUNT_BITS-1:0] MAX_POSITION_RST = COUNT_BITS'(12990);
  localparam logic [TICK_BITS-1:0]  PULSE_TICKS_RST  = TICK_BITS'(1);

  // Request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BOUND   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // Command characters
  localparam logic [7:0] CH_JOG_1    = 8'h61; // 'a'
  localparam logic [7:0] CH_JOG_10   = 8'h62; // 'b'
  localparam logic [7:0] CH_JOG_100  = 8'h63; // 'c'
  localparam logic [7:0] CH_JOG_1000 = 8'h64; // 'd'
  localparam logic [7:0] CH_DIR_IN   = 8'h65; // 'e'
  localparam logic [7:0] CH_DIR_OUT  = 8'h66; // 'f'
  localparam logic [7:0] CH_DUMP     = 8'h6f; // 'o'
  localparam logic [7:0] CH_JOG_ON   = 8'h78; // 'x'
  localparam logic [7:0] CH_JOG_SEND = 8'h79; // 'y'

  localparam logic [COUNT_BITS-1:0] INC_1    = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] INC_10   = COUNT_BITS'(10);
  localparam logic [COUNT_BITS-1:0] INC_100  = COUNT_BITS'(100);
  localparam logic [COUNT_BITS-1:0] INC_1000 = COUNT_BITS'(1000);

  typedef struct packed {
    logic                  step_level;
    logic                  dir_level;
    logic [COUNT_BITS-1:0] position_now;
    logic [1:0]            status;
    logic                  motor_busy;
  } result_t;

endpackage

>>> design/pcsc_if.sv
// Handshake channel interfaces for command/tick items and result items.
interface pcsc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface pcsc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            step_level;
  logic                            dir_level;
  logic [pcsc_pkg::COUNT_BITS-1:0] position_now;
  logic [1:0]                      status;
  logic                            motor_busy;

  modport source (output valid, output step_level, output dir_level, output position_now,
                  output status, output motor_busy, input ready);
  modport sink   (input valid, input step_level, input dir_level, input position_now,
                  input status, input motor_busy, output ready);
endinterface

>>> design/pump_command_step_controller.sv
// Pump command step controller: command decode, jog tracking, step pulse generation.
//
// Channels: cmd takes one item per handshake, either a received command byte
// (req_type 0, rx_byte) or one time tick (req_type 1). res returns exactly one
// result item per cmd item, in order: step level, direction level, tracked
// position, status and busy flag, all as they stand after that item.
// Configuration: cfg_we/cfg_index/cfg_data write max_position (index 0) or
// pulse_ticks (index 1); other indexes are ignored. Write only while idle.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle while res.ready is high; the whole state
// update is one pass of logic between the state and result registers.
// Stall: while a result waits in the result register and res.ready is low,
// cmd.ready is low; it rises again in the cycle the result is taken, so a new
// item can enter in the same cycle the held one leaves.
// Reset (rst, synchronous): idle mode, position and counts zero, direction
// outward, no pending steps, registers back to 12990 and 1, no result held.
module pump_command_step_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pcsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [pcsc_pkg::CFG_BITS-1:0]     cfg_data,
  pcsc_in_if.sink                           cmd,
  pcsc_out_if.source                        res
);

  localparam int CB = pcsc_pkg::COUNT_BITS;
  localparam int TB = pcsc_pkg::TICK_BITS;

  logic [CB-1:0] max_position;
  logic [TB-1:0] pulse_ticks;

  logic          jog_mode, jog_mode_next;
  logic [CB-1:0] position, position_next;
  logic [CB-1:0] jog_count, jog_count_next;
  logic          direction, direction_next;
  logic [CB-1:0] active_steps, active_steps_next;
  logic          pulse_high, pulse_high_next;
  logic [TB-1:0] tick_count, tick_count_next;
  logic          pending_valid, pending_valid_next;
  logic [CB-1:0] pending_count, pending_count_next;

  logic                  res_valid;
  pcsc_pkg::result_t     result, result_next;
  logic [1:0]            st;
  logic                  accept;

  // Jog move and step tick datapath
  logic [CB-1:0] inc;
  logic          inc_hit;
  logic [CB:0]   up_sum;
  logic          move_abort;
  logic [CB:0]   jog_sum;
  logic [TB-1:0] half;
  logic [TB-1:0] tick_inc;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    case (cmd.rx_byte)
      pcsc_pkg::CH_JOG_1: begin
        inc = pcsc_pkg::INC_1; inc_hit = 1'b1;
      end
      pcsc_pkg::CH_JOG_10: begin
        inc = pcsc_pkg::INC_10; inc_hit = 1'b1;
      end
      pcsc_pkg::CH_JOG_100: begin
        inc = pcsc_pkg::INC_100; inc_hit = 1'b1;
      end
      pcsc_pkg::CH_JOG_1000: begin
        inc = pcsc_pkg::INC_1000; inc_hit = 1'b1;
      end
      default: begin
        inc = '0; inc_hit = 1'b0;
      end
    endcase
  end

  assign up_sum     = {1'b0, position} + {1'b0, inc};
  assign move_abort = direction ? (up_sum > {1'b0, max_position}) : (position < inc);
  assign jog_sum    = {1'b0, jog_count} + {1'b0, inc};
  assign half       = (pulse_ticks == '0) ? TB'(1) : pulse_ticks;
  assign tick_inc   = tick_count + TB'(1);

  always_comb begin
    logic          send;
    logic [CB-1:0] send_count;
    jog_mode_next      = jog_mode;
    position_next      = position;
    jog_count_next     = jog_count;
    direction_next     = direction;
    active_steps_next  = active_steps;
    pulse_high_next    = pulse_high;
    tick_count_next    = tick_count;
    pending_valid_next = pending_valid;
    pending_count_next = pending_count;
    st                 = pcsc_pkg::ST_OK;
    send               = 1'b0;
    send_count         = jog_count;

    if (cmd.req_type == pcsc_pkg::REQ_TICK) begin
      if (active_steps != '0) begin
        tick_count_next = tick_inc;
        if (tick_inc >= half) begin
          tick_count_next = '0;
          if (pulse_high) begin
            pulse_high_next = 1'b0;
          end else begin
            active_steps_next = active_steps - CB'(1);
            pulse_high_next   = (active_steps != CB'(1));
          end
        end
      end
    end else if (jog_mode) begin
      if (inc_hit) begin
        if (move_abort) begin
          jog_mode_next  = 1'b0;
          jog_count_next = '0;
          st             = pcsc_pkg::ST_BOUND;
        end else begin
          position_next  = direction ? up_sum[CB-1:0] : (position - inc);
          // saturate the jog count
          jog_count_next = jog_sum[CB] ? pcsc_pkg::COUNT_MAX : jog_sum[CB-1:0];
        end
      end else if (cmd.rx_byte == pcsc_pkg::CH_JOG_SEND) begin
        send           = 1'b1;
        send_count     = jog_count;
        jog_count_next = '0;
        jog_mode_next  = 1'b0;
      end else begin
        st = pcsc_pkg::ST_IGNORED;
      end
    end else begin
      case (cmd.rx_byte)
        pcsc_pkg::CH_DIR_IN:  direction_next = 1'b0;
        pcsc_pkg::CH_DIR_OUT: direction_next = 1'b1;
        pcsc_pkg::CH_DUMP: begin
          direction_next = 1'b0;
          send           = 1'b1;
          send_count     = position;
          position_next  = '0;
        end
        pcsc_pkg::CH_JOG_ON: begin
          jog_mode_next  = 1'b1;
          jog_count_next = '0;
        end
        default: st = pcsc_pkg::ST_IGNORED;
      endcase
    end

    // One-entry queue: drop and flag a send while it is full
    if (send) begin
      if (pending_valid) begin
        st = pcsc_pkg::ST_FULL;
      end else begin
        pending_valid_next = 1'b1;
        pending_count_next = send_count;
      end
    end

    // Hand the pending entry to the generator once it runs dry
    if (active_steps_next == '0 && pending_valid_next) begin
      active_steps_next  = pending_count_next;
      pending_valid_next = 1'b0;
      tick_count_next    = '0;
      pulse_high_next    = (pending_count_next != '0);
    end

    result_next.step_level   = pulse_high_next;
    result_next.dir_level    = direction_next;
    result_next.position_now = position_next;
    result_next.status       = st;
    result_next.motor_busy   = (active_steps_next != '0) || pending_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_position <= pcsc_pkg::MAX_POSITION_RST;
      pulse_ticks  <= pcsc_pkg::PULSE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pcsc_pkg::REG_MAX_POSITION: max_position <= cfg_data;
        pcsc_pkg::REG_PULSE_TICKS:  pulse_ticks  <= cfg_data[TB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jog_mode      <= 1'b0;
      position      <= '0;
      jog_count     <= '0;
      direction     <= 1'b1;
      active_steps  <= '0;
      pulse_high    <= 1'b0;
      tick_count    <= '0;
      pending_valid <= 1'b0;
      pending_count <= '0;
    end else if (accept) begin
      jog_mode      <= jog_mode_next;
      position      <= position_next;
      jog_count     <= jog_count_next;
      direction     <= direction_next;
      active_steps  <= active_steps_next;
      pulse_high    <= pulse_high_next;
      tick_count    <= tick_count_next;
      pending_valid <= pending_valid_next;
      pending_count <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign res.valid        = res_valid;
  assign res.step_level   = result.step_level;
  assign res.dir_level    = result.dir_level;
  assign res.position_now = result.position_now;
  assign res.status       = result.status;
  assign res.motor_busy   = result.motor_busy;

  a_pending_only_behind_active: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> (active_steps != '0))
    else $error("pending entry held while generator is idle");

  a_high_needs_steps: assert property (@(posedge clk) disable iff (rst)
    pulse_high |-> (active_steps != '0))
    else $error("step output high with no active steps");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted item produced no result");

  a_full_only_when_pending: assert property (@(posedge clk) disable iff (rst)
    (accept && result_next.status == pcsc_pkg::ST_FULL) |-> pending_valid)
    else $error("queue full flagged with empty queue");

endmodule

>>> verif/pump_result_checker.sv
// Result checker for the pump controller: predicts each result item and compares it.
module pump_result_checker
  import pcsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  pcsc_in_if                      cmd,
  pcsc_out_if                     res,
  output int                      fail_count,
  output int                      results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic [COUNT_BITS-1:0] max_pos;
  logic [TICK_BITS-1:0]  half_ticks;

  // Controller state
  logic                  jog_on;
  logic                  dir_out;
  logic                  level_high;
  logic                  queued;
  logic [COUNT_BITS-1:0] pos;
  logic [COUNT_BITS-1:0] jog_cnt;
  logic [COUNT_BITS-1:0] steps_left;
  logic [COUNT_BITS-1:0] queued_cnt;
  logic [TICK_BITS-1:0]  tick_cnt;

  result_t expected_results[$];
  int      fails = 0;

  function automatic logic [1:0] queue_steps(input logic [COUNT_BITS-1:0] cnt);
    if (queued) return ST_FULL;
    queued     = 1'b1;
    queued_cnt = cnt;
    return ST_OK;
  endfunction

  function automatic logic [1:0] jog_step(input logic [COUNT_BITS-1:0] inc);
    int target;
    int sum;
    if (dir_out) begin
      target = int'(pos) + int'(inc);
      if (target > int'(max_pos) || target > int'(COUNT_MAX)) begin
        jog_on  = 1'b0;
        jog_cnt = '0;
        return ST_BOUND;
      end
    end else begin
      if (pos < inc) begin
        jog_on  = 1'b0;
        jog_cnt = '0;
        return ST_BOUND;
      end
      target = int'(pos) - int'(inc);
    end
    pos = COUNT_BITS'(target);
    sum = int'(jog_cnt) + int'(inc);
    jog_cnt = (sum > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(sum);
    return ST_OK;
  endfunction

  function automatic void tick_pulse();
    logic [TICK_BITS-1:0] half;
    half = (half_ticks == '0) ? TICK_BITS'(1) : half_ticks;
    if (steps_left == '0) return;
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= half) begin
      tick_cnt = '0;
      if (level_high) begin
        level_high = 1'b0;
      end else begin
        // low half done: the step is complete
        steps_left = steps_left - 1'b1;
        level_high = (steps_left != '0);
      end
    end
  endfunction

  function automatic logic [1:0] decode_byte(input logic [7:0] ch);
    logic [1:0] st;
    st = ST_OK;
    if (jog_on) begin
      case (ch)
        CH_JOG_1:    st = jog_step(INC_1);
        CH_JOG_10:   st = jog_step(INC_10);
        CH_JOG_100:  st = jog_step(INC_100);
        CH_JOG_1000: st = jog_step(INC_1000);
        CH_JOG_SEND: begin
          st      = queue_steps(jog_cnt);
          jog_cnt = '0;
          jog_on  = 1'b0;
        end
        default:     st = ST_IGNORED;
      endcase
    end else begin
      case (ch)
        CH_DIR_IN:  dir_out = 1'b0;
        CH_DIR_OUT: dir_out = 1'b1;
        CH_DUMP: begin
          dir_out = 1'b0;
          st      = queue_steps(pos);
          pos     = '0;
        end
        CH_JOG_ON: begin
          jog_on  = 1'b1;
          jog_cnt = '0;
        end
        default:    st = ST_IGNORED;
      endcase
    end
    return st;
  endfunction

  function automatic result_t pump_predict(input logic kind, input logic [7:0] ch);
    result_t r;
    logic [1:0] st;
    st = ST_OK;
    if (kind == REQ_TICK) tick_pulse();
    else st = decode_byte(ch);
    // hand the pending entry to an idle generator in the same item
    if (steps_left == '0 && queued) begin
      steps_left = queued_cnt;
      queued     = 1'b0;
      tick_cnt   = '0;
      level_high = (steps_left != '0);
    end
    r.step_level   = level_high;
    r.dir_level    = dir_out;
    r.position_now = pos;
    r.status       = st;
    r.motor_busy   = (steps_left != '0) || queued;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      max_pos    = MAX_POSITION_RST;
      half_ticks = PULSE_TICKS_RST;
      jog_on     = 1'b0;
      dir_out    = 1'b1;
      level_high = 1'b0;
      queued     = 1'b0;
      pos        = '0;
      jog_cnt    = '0;
      steps_left = '0;
      queued_cnt = '0;
      tick_cnt   = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_POSITION) max_pos = cfg_data[COUNT_BITS-1:0];
        else if (cfg_index == REG_PULSE_TICKS) half_ticks = cfg_data[TICK_BITS-1:0];
      end
      // retire before predicting: a result never belongs to an item accepted at this edge
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (res.step_level !== want.step_level) begin
            $error("step_level: expected %0d, got %0d", want.step_level, res.step_level);
            fails++;
          end
          if (res.dir_level !== want.dir_level) begin
            $error("dir_level: expected %0d, got %0d", want.dir_level, res.dir_level);
            fails++;
          end
          if (res.position_now !== want.position_now) begin
            $error("position_now: expected %0d, got %0d", want.position_now,
                   res.position_now);
            fails++;
          end
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            fails++;
          end
          if (res.motor_busy !== want.motor_busy) begin
            $error("motor_busy: expected %0d, got %0d", want.motor_busy, res.motor_busy);
            fails++;
          end
        end
      end
      if (cmd.valid && cmd.ready)
        expected_results.push_back(pump_predict(cmd.req_type, cmd.rx_byte));
    end
    fail_count   <= fails;
    results_owed <= expected_results.size();
  end

endmodule

>>> verif/pump_command_step_controller_tb.sv
// Top of the pump controller testbench: clock, reset, stimulus and verdict.
module pump_command_step_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcsc_pkg::*;

  localparam int PHASES     = 7;
  localparam int PHASE_ITEMS = 200;
  localparam logic [COUNT_BITS-1:0] PHASE_LIMIT [PHASES] =
    '{COUNT_MAX, 14'd0, 14'd1500, 14'd200, MAX_POSITION_RST, 14'd3000, COUNT_MAX};
  localparam logic [TICK_BITS-1:0] PHASE_HALF [PHASES] =
    '{8'd1, 8'd0, 8'd3, 8'd255, 8'd1, 8'd2, 8'd7};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;
  logic                    rx_ready = 1'b0;
  int                      fail_count;
  int                      results_owed;

  int unsigned burst_left  = 0;
  int unsigned items_sent  = 0;
  bit          sender_gaps = 1'b1;

  int unsigned sink_cycle = 0;
  int unsigned sink_mode  = 0;
  int unsigned sink_hold  = 0;

  pcsc_in_if  cmd_ch ();
  pcsc_out_if res_ch ();

  assign res_ch.ready = rx_ready;

  pump_command_step_controller uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  pump_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd_ch),
    .res          (res_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: periodically pick a random stall pattern (none, short frequent, long rare)
  always @(posedge clk) begin
    sink_cycle++;
    if (sink_cycle % 256 == 0) sink_mode = $urandom_range(0, 2);
    if (sink_hold != 0) begin
      sink_hold--;
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= 1'b1;
      case (sink_mode)
        1: if ($urandom_range(0, 3) == 0) sink_hold = $urandom_range(1, 3);
        2: if ($urandom_range(0, 9) == 0) sink_hold = $urandom_range(4, 12);
        default: ;
      endcase
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      // drop valid only for a real gap, so it is never lowered and raised in one step
      if (gap != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.req_type <= kind;
    cmd_ch.rx_byte  <= ch;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] ch);
    send_item(REQ_BYTE, ch);
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 8'($urandom));
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [COUNT_BITS-1:0] limit_pos,
                             input logic [TICK_BITS-1:0] half);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_POSITION;
    cfg_data  <= limit_pos;
    @(posedge clk);
    // upper bits of the tick register write are junk and must be dropped
    cfg_index <= REG_PULSE_TICKS;
    cfg_data  <= {(CFG_BITS-TICK_BITS)'($urandom), half};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    int unsigned r;
    start = items_sent;
    while (items_sent - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // jog session with random moves, mostly closed by a send
        if ($urandom_range(0, 1) == 1)
          send_byte(($urandom_range(0, 1) == 1) ? CH_DIR_OUT : CH_DIR_IN);
        send_byte(CH_JOG_ON);
        repeat ($urandom_range(1, 12)) begin
          r = $urandom_range(0, 99);
          if (r < 5)       send_byte(8'($urandom));
          else if (r < 35) send_byte(CH_JOG_1);
          else if (r < 65) send_byte(CH_JOG_10);
          else if (r < 85) send_byte(CH_JOG_100);
          else             send_byte(CH_JOG_1000);
        end
        if ($urandom_range(0, 9) != 0) send_byte(CH_JOG_SEND);
        repeat ($urandom_range(0, 30)) send_tick();
      end else if (pick < 70) begin
        send_byte(CH_DUMP);
        repeat ($urandom_range(0, 20)) send_tick();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 40)) send_tick();
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    cmd_ch.valid    <= 1'b0;
    cmd_ch.req_type <= REQ_BYTE;
    cmd_ch.rx_byte  <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_MAX_POSITION;
    cfg_data        <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed pass at reset settings
    send_item(REQ_TICK, 8'hFF);
    send_byte(CH_JOG_1);
    send_byte(CH_JOG_SEND);
    send_byte(CH_DUMP);
    send_byte(CH_DIR_OUT);
    send_byte(CH_JOG_ON);
    send_byte(CH_DIR_IN);
    send_byte(CH_JOG_1000);
    send_byte(CH_JOG_100);
    send_byte(CH_JOG_10);
    send_byte(CH_JOG_1);
    send_byte(CH_JOG_SEND);
    send_byte(CH_JOG_ON);
    send_byte(CH_JOG_1);
    send_byte(CH_JOG_SEND);
    send_byte(CH_JOG_ON);
    send_byte(CH_JOG_SEND);
    send_byte(CH_DUMP);
    send_byte(CH_JOG_ON);
    send_byte(CH_JOG_1);
    send_tick();
    send_byte(8'h00);
    send_item(REQ_TICK, 8'h00);
    send_byte(CH_DIR_IN);
    send_tick();
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      load_config(PHASE_LIMIT[p], PHASE_HALF[p]);
      random_traffic(PHASE_ITEMS);
      drain_results();
    end

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
